### rtl/rotenc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event queue package
// Shared widths, operation and register codes, controller states and the
// command bundle between controller and datapath.
// ----------------------------------------------------------------------------
package rotenc_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 16;

    // The channel field and the masks reach eight channels at most.
    localparam int MAX_CHANNELS = 8;

    localparam int FUNC_W     = 2;
    localparam int CH_W       = 3;
    localparam int CODE_W     = 2;
    localparam int LOCKOUT_W  = 16;
    localparam int MASK_W     = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd10;

    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd2;

    localparam logic [CODE_W-1:0] EVT_NONE    = 2'd0;
    localparam logic [CODE_W-1:0] EVT_LEFT    = 2'd1;
    localparam logic [CODE_W-1:0] EVT_RIGHT   = 2'd2;
    localparam logic [CODE_W-1:0] EVT_INVALID = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGISTERED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic commit;
    } dp_cmd_t;

endpackage

### rtl/rotary_encoder_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event queue
// Per-channel direction decoding with edge lockout and one ring queue of
// events per channel.
// ----------------------------------------------------------------------------
// Each transaction (tick, falling B edge or pop) goes through a capture step,
// an evaluate step that compares the elapsed time against the lockout and
// reads the queue memory, whose read data is registered, and a commit step
// that updates pointers, stamps and the result register. The next transaction
// is accepted in the cycle after the commit, even while the previous result
// still waits to be taken; a commit waits only while the result register is
// still occupied. A queue holds at most QUEUE_DEPTH-1 events. No clearing pass
// is needed after reset: read data is only used from slots already written.
// ----------------------------------------------------------------------------
module rotary_encoder_event_queue
    import rotenc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [CH_W-1:0]       s_channel,
    input  logic                  s_level_a,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CODE_W-1:0]     m_event_code,
    output logic                  m_dropped,
    output logic                  m_pending
);

    dp_cmd_t cmd;

    rotenc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    rotenc_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_func       (s_func),
        .s_channel    (s_channel),
        .s_level_a    (s_level_a),
        .m_event_code (m_event_code),
        .m_dropped    (m_dropped),
        .m_pending    (m_pending)
    );

    // With the result register free, an accepted transaction passes evaluate and commit, then sets valid.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |-> ##3 m_valid)
        else $error("result did not appear three cycles after acceptance");

    // A drop only happens on a full queue, which is never empty afterwards.
    a_drop_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dropped) |-> m_pending)
        else $error("dropped event reported with an empty queue");

    // Drops come from edges, event codes from pops; never both at once.
    a_drop_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dropped) |-> (m_event_code == EVT_NONE))
        else $error("dropped flag set together with an event code");

endmodule

### rtl/rotenc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event queue controller
// Sequences each transaction through capture, evaluate and commit, and owns
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module rotenc_ctrl
    import rotenc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // Nothing is taken while reset is held.
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.evaluate = 1'b1;
                state_next   = ST_COMMIT;
            end
            ST_COMMIT: begin
                // The update is held back until the result register is free.
                if (!out_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

### rtl/rotenc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event queue datapath
// Configuration registers, time counter, per-channel lockout stamps and queue
// pointers, the event bit memory and the result register.
// ----------------------------------------------------------------------------
module rotenc_datapath
    import rotenc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [CH_W-1:0]       s_channel,
    input  logic                  s_level_a,
    output logic [CODE_W-1:0]     m_event_code,
    output logic                  m_dropped,
    output logic                  m_pending
);

    // Only channels the channel field can name get storage.
    localparam int NUM_STORED = (NUM_CHANNELS < MAX_CHANNELS) ? NUM_CHANNELS : MAX_CHANNELS;
    localparam int CH_IDX_W   = (NUM_STORED > 1) ? $clog2(NUM_STORED) : 1;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int MEM_DEPTH  = NUM_STORED * QUEUE_DEPTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // Configuration registers
    logic [LOCKOUT_W-1:0] lockout_reg;
    logic [MASK_W-1:0]    registered_reg;
    logic [MASK_W-1:0]    enable_reg;

    // Captured transaction
    logic [FUNC_W-1:0] func_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              level_a_reg;

    // Channel state
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] start_reg [NUM_STORED];
    logic [PTR_W-1:0]  rd_ptr_reg [NUM_STORED];
    logic [PTR_W-1:0]  wr_ptr_reg [NUM_STORED];
    logic              event_mem [MEM_DEPTH];

    logic edge_ok_reg, edge_ok_next;
    logic mem_rdata_reg;

    logic [CODE_W-1:0] code_reg, code_next;
    logic              dropped_reg, dropped_next;
    logic              pending_reg, pending_next;

    logic [CH_IDX_W-1:0] ch_idx;
    logic                ch_valid;
    logic                ch_exists;
    logic [TIME_W-1:0]   sel_start;
    logic [PTR_W-1:0]    sel_rd, sel_wr;
    logic [PTR_W-1:0]    rd_ptr_next, wr_ptr_next;
    logic                q_empty, q_full;
    logic [TIME_W-1:0]   elapsed;
    logic [ADDR_W-1:0]   base_addr, rd_addr, wr_addr;
    logic                mem_we;
    logic                start_we;
    logic [TIME_W-1:0]   time_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockout_reg    <= LOCKOUT_RESET;
            registered_reg <= '0;
            enable_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOCKOUT:    lockout_reg    <= cfg_wdata;
                REG_REGISTERED: registered_reg <= cfg_wdata[MASK_W-1:0];
                REG_ENABLE:     enable_reg     <= cfg_wdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= s_func;
            ch_reg      <= s_channel;
            level_a_reg <= s_level_a;
        end
    end

    assign ch_idx    = ch_reg[CH_IDX_W-1:0];
    assign ch_valid  = {1'b0, ch_reg} < (CH_W + 1)'(NUM_STORED);
    assign ch_exists = ch_valid && registered_reg[ch_reg];
    assign sel_start = ch_valid ? start_reg[ch_idx]  : '0;
    assign sel_rd    = ch_valid ? rd_ptr_reg[ch_idx] : '0;
    assign sel_wr    = ch_valid ? wr_ptr_reg[ch_idx] : '0;
    assign q_empty   = (sel_rd == sel_wr);
    assign q_full    = (next_ptr(sel_wr) == sel_rd);

    // Elapsed time wraps with the counter.
    assign elapsed      = time_reg - sel_start;
    assign edge_ok_next = ch_exists && enable_reg[ch_reg] &&
                          (elapsed >= {{(TIME_W - LOCKOUT_W){1'b0}}, lockout_reg});

    assign base_addr = ADDR_W'(int'(ch_idx) * QUEUE_DEPTH);
    assign rd_addr   = base_addr + ADDR_W'(sel_rd);
    assign wr_addr   = base_addr + ADDR_W'(sel_wr);

    always_comb begin
        code_next    = EVT_NONE;
        dropped_next = 1'b0;
        rd_ptr_next  = sel_rd;
        wr_ptr_next  = sel_wr;
        mem_we       = 1'b0;
        start_we     = 1'b0;
        time_next    = time_reg;
        case (func_reg)
            FUNC_TICK: begin
                time_next = time_reg + TIME_W'(1);
            end
            FUNC_EDGE: begin
                if (edge_ok_reg) begin
                    // A full queue loses the event but the lockout restarts.
                    start_we = 1'b1;
                    if (q_full) begin
                        dropped_next = 1'b1;
                    end else begin
                        mem_we      = 1'b1;
                        wr_ptr_next = next_ptr(sel_wr);
                    end
                end
            end
            FUNC_POP: begin
                if (!ch_exists) begin
                    code_next = EVT_INVALID;
                end else if (!q_empty) begin
                    code_next   = mem_rdata_reg ? EVT_LEFT : EVT_RIGHT;
                    rd_ptr_next = next_ptr(sel_rd);
                end
            end
            default: begin
            end
        endcase
        pending_next = ch_valid && (rd_ptr_next != wr_ptr_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.evaluate) begin
            edge_ok_reg   <= edge_ok_next;
            mem_rdata_reg <= event_mem[rd_addr];
        end
        if (cmd.commit && mem_we) begin
            event_mem[wr_addr] <= level_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            for (int i = 0; i < NUM_STORED; i++) begin
                start_reg[i]  <= '0;
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            time_reg <= time_next;
            if (ch_valid) begin
                rd_ptr_reg[ch_idx] <= rd_ptr_next;
                wr_ptr_reg[ch_idx] <= wr_ptr_next;
                if (start_we) begin
                    start_reg[ch_idx] <= time_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            code_reg    <= code_next;
            dropped_reg <= dropped_next;
            pending_reg <= pending_next;
        end
    end

    assign m_event_code = code_reg;
    assign m_dropped    = dropped_reg;
    assign m_pending    = pending_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event queue testbench
// Directed tests cover reset values, both directions, lockout, queue full
// and the channel masks. Random phases then run under several register
// settings, with random stalls on both sides in all but the last. Every result is compared with
// a behavioral copy of the block that is updated as each transaction is
// accepted.
// ----------------------------------------------------------------------------
module tb_top;
    import rotenc_pkg::*;

    localparam int NCH         = NUM_CHANNELS_DEF;
    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int QP_W        = $clog2(QDEPTH);
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    // The one function code that does nothing.
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              dropped;
        logic              pending;
    } enc_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func = FUNC_TICK;
    logic [CH_W-1:0]       s_channel = '0;
    logic                  s_level_a = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CODE_W-1:0]     m_event_code;
    logic                  m_dropped;
    logic                  m_pending;

    // Behavioral copy of the decoder state and its registers.
    logic [LOCKOUT_W-1:0]  mdl_lockout;
    logic [MASK_W-1:0]     mdl_registered;
    logic [MASK_W-1:0]     mdl_enabled;
    logic [TIME_W-1:0]     mdl_time;
    logic [TIME_W-1:0]     mdl_stamp [NCH];
    logic                  mdl_dir   [NCH][QDEPTH];
    logic [QP_W-1:0]       mdl_rd    [NCH];
    logic [QP_W-1:0]       mdl_wr    [NCH];

    enc_result_t expected_events[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_hold_cycles = 0;
    int unsigned rx_gap_left = 0;
    bit          idle_on = 1'b1;

    rotary_encoder_event_queue u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_channel    (s_channel),
        .s_level_a    (s_level_a),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .m_dropped    (m_dropped),
        .m_pending    (m_pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Applies one transaction to the behavioral copy and returns its result.
    task automatic encoder_step(input logic [FUNC_W-1:0] func, input logic [CH_W-1:0] ch,
                                input logic a, output enc_result_t res);
        logic [QP_W-1:0] nxt;
        logic            known;
        res = '0;
        known = mdl_registered[ch];
        if (func == FUNC_TICK) begin
            mdl_time = mdl_time + 1;
        end else if (func == FUNC_EDGE) begin
            if (known && mdl_enabled[ch] &&
                (mdl_time - mdl_stamp[ch]) >= {16'd0, mdl_lockout}) begin
                nxt = (mdl_wr[ch] == QP_W'(QDEPTH - 1)) ? '0 : mdl_wr[ch] + 1'b1;
                if (nxt == mdl_rd[ch]) begin
                    res.dropped = 1'b1;
                end else begin
                    mdl_dir[ch][mdl_wr[ch]] = a;
                    mdl_wr[ch] = nxt;
                end
                mdl_stamp[ch] = mdl_time;
            end
        end else if (func == FUNC_POP) begin
            if (!known) begin
                res.code = EVT_INVALID;
            end else if (mdl_rd[ch] != mdl_wr[ch]) begin
                res.code = mdl_dir[ch][mdl_rd[ch]] ? EVT_LEFT : EVT_RIGHT;
                mdl_rd[ch] = (mdl_rd[ch] == QP_W'(QDEPTH - 1)) ? '0 : mdl_rd[ch] + 1'b1;
            end
        end
        res.pending = (mdl_rd[ch] != mdl_wr[ch]);
    endtask

    // Predicts on input transactions and checks output transactions.
    always @(posedge aclk) begin : scoreboard
        enc_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                encoder_step(s_func, s_channel, s_level_a, want);
                expected_events.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("result transaction with no expected result waiting");
                    fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_event_code !== want.code) begin
                        $error("event_code mismatch: expected %0d, actual %0d",
                               want.code, m_event_code);
                        fail_count++;
                    end
                    if (m_dropped !== want.dropped) begin
                        $error("dropped mismatch: expected %0d, actual %0d",
                               want.dropped, m_dropped);
                        fail_count++;
                    end
                    if (m_pending !== want.pending) begin
                        $error("pending mismatch: expected %0d, actual %0d",
                               want.pending, m_pending);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result side: a long hold when requested, otherwise short random stalls while idle_on is set.
    always @(posedge aclk) begin
        if (rx_hold_cycles != 0) begin
            rx_hold_cycles--;
            m_ready <= 1'b0;
        end else if (rx_gap_left != 0) begin
            rx_gap_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_gap_left = $urandom_range(1, 5) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Leaves valid high after acceptance so back-to-back transactions need
    // no drop of valid; close_burst lowers it.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [CH_W-1:0] ch,
                             input logic a);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= func;
        s_channel <= ch;
        s_level_a <= a;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic close_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drain();
        close_burst();
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Leaves the write enable high; set_regs lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_LOCKOUT:    mdl_lockout = data;
            REG_REGISTERED: mdl_registered = data[MASK_W-1:0];
            REG_ENABLE:     mdl_enabled = data[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [LOCKOUT_W-1:0] lockout,
                            input logic [MASK_W-1:0] reg_mask, input logic [MASK_W-1:0] en_mask);
        wait_drain();
        write_reg(REG_LOCKOUT, lockout);
        write_reg(REG_REGISTERED, {8'd0, reg_mask});
        write_reg(REG_ENABLE, {8'd0, en_mask});
        cfg_we <= 1'b0;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_item(FUNC_TICK, '0, 1'($urandom_range(0, 1)));
    endtask

    // Half of the channels come from a narrow set so that queues fill up.
    task automatic send_random(input int unsigned count);
        int unsigned pick;
        logic [FUNC_W-1:0] func;
        logic [CH_W-1:0]   ch;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      func = FUNC_TICK;
            else if (pick < 72) func = FUNC_EDGE;
            else if (pick < 95) func = FUNC_POP;
            else                func = FUNC_NOP;
            if ($urandom_range(0, 1) == 0) ch = CH_W'($urandom_range(0, 1));
            else                           ch = CH_W'($urandom_range(0, NCH - 1));
            send_item(func, ch, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_reset_values();
        send_item(FUNC_EDGE, 3'd0, 1'b1);
        send_item(FUNC_POP, 3'd0, 1'b0);
        send_item(FUNC_NOP, 3'd7, 1'b1);
        set_regs(LOCKOUT_RESET, 8'hFF, 8'hFF);
        // The first edge after reset still has to wait out the lockout.
        send_item(FUNC_EDGE, 3'd1, 1'b1);
        send_ticks(int'(LOCKOUT_RESET));
        send_item(FUNC_EDGE, 3'd1, 1'b0);
        send_item(FUNC_POP, 3'd1, 1'b0);
        send_item(FUNC_POP, 3'd1, 1'b0);
    endtask

    task automatic test_directions();
        set_regs(16'd0, 8'hFF, 8'hFF);
        send_item(FUNC_EDGE, 3'd7, 1'b1);
        send_item(FUNC_EDGE, 3'd7, 1'b0);
        send_item(FUNC_EDGE, 3'd0, 1'b0);
        send_item(FUNC_POP, 3'd7, 1'b0);
        send_item(FUNC_POP, 3'd7, 1'b1);
        send_item(FUNC_POP, 3'd7, 1'b0);
        send_item(FUNC_POP, 3'd0, 1'b1);
    endtask

    task automatic test_lockout();
        set_regs(16'd40, 8'hFF, 8'hFF);
        send_ticks(40);
        send_item(FUNC_EDGE, 3'd5, 1'b1);
        send_item(FUNC_EDGE, 3'd5, 1'b0);
        send_ticks(39);
        send_item(FUNC_EDGE, 3'd5, 1'b0);
        send_item(FUNC_TICK, 3'd5, 1'b0);
        send_item(FUNC_EDGE, 3'd5, 1'b0);
        set_regs(16'hFFFF, 8'hFF, 8'hFF);
        send_ticks(5);
        send_item(FUNC_EDGE, 3'd6, 1'b1);
        send_item(FUNC_POP, 3'd5, 1'b0);
        send_item(FUNC_POP, 3'd5, 1'b0);
    endtask

    // A full queue drops the edge but still restarts the lockout.
    task automatic test_queue_full();
        set_regs(16'd0, 8'hFF, 8'hFF);
        repeat (QDEPTH + 1) send_item(FUNC_EDGE, 3'd3, 1'($urandom_range(0, 1)));
        repeat (QDEPTH) send_item(FUNC_POP, 3'd3, 1'b0);
    endtask

    task automatic test_masks();
        set_regs(16'd0, 8'hFF, 8'hEF);
        send_item(FUNC_EDGE, 3'd4, 1'b1);
        send_item(FUNC_POP, 3'd4, 1'b1);
        send_item(FUNC_EDGE, 3'd2, 1'b1);
        send_item(FUNC_EDGE, 3'd2, 1'b0);
        // Unregistering keeps the stored queue, which pending still shows.
        set_regs(16'd0, 8'hFB, 8'hFF);
        send_item(FUNC_POP, 3'd2, 1'b0);
        send_item(FUNC_EDGE, 3'd2, 1'b1);
        set_regs(16'd0, 8'hFF, 8'h00);
        repeat (3) send_item(FUNC_POP, 3'd2, 1'b0);
        send_item(FUNC_EDGE, 3'd2, 1'b1);
    endtask

    task automatic test_backpressure();
        set_regs(16'd0, 8'hFF, 8'hFF);
        rx_hold_cycles = HOLD_CYCLES;
        send_random(40);
        wait_drain();
    endtask

    task automatic test_random();
        set_regs(16'd0, 8'hFF, 8'hFF);
        send_random(200);
        set_regs(16'd2, MASK_W'($urandom_range(0, 255)), MASK_W'($urandom_range(0, 255)));
        send_random(150);
        set_regs(LOCKOUT_W'($urandom_range(1, 6)), 8'hFF, MASK_W'($urandom_range(0, 255)));
        send_random(100);
        set_regs(16'd1, 8'hFF, 8'hFF);
        idle_on = 1'b0;
        send_random(100);
    endtask

    initial begin
        mdl_lockout    = LOCKOUT_RESET;
        mdl_registered = '0;
        mdl_enabled    = '0;
        mdl_time       = '0;
        for (int c = 0; c < NCH; c++) begin
            mdl_stamp[c] = '0;
            mdl_rd[c]    = '0;
            mdl_wr[c]    = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_directions();
        test_lockout();
        test_queue_full();
        test_masks();
        test_backpressure();
        test_random();

        wait_drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
